// ----- design/afr_pkg.sv -----
`default_nettype none
package afr_pkg;

   localparam int START_COUNT = 2;
   localparam int MAX_FRAME   = 64;
   localparam int LEN_MIN     = START_COUNT + 5;

   localparam int COUNT_W = 7;
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 16;
   localparam int TICK_W  = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_START = 2'd1,
      ERR_ADDR  = 2'd2,
      ERR_SUM   = 2'd3
   } cause_type;

   typedef enum logic [1:0] {
      CSR_FRAME_LENGTH   = 2'd0,
      CSR_DEVICE_ADDRESS = 2'd1,
      CSR_SYNC_BYTE      = 2'd2,
      CSR_TIMEOUT_TICKS  = 2'd3
   } csr_index_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
   } entry_type;

   typedef struct packed {
      logic [COUNT_W-1:0] frame_length;
      logic [BYTE_W-1:0]  device_address;
      logic [BYTE_W-1:0]  sync_byte;
      logic [TICK_W-1:0]  timeout_ticks;
   } cfg_type;

   // clamp the programmed length into the supported range
   function automatic logic [COUNT_W-1:0] eff_length(input logic [COUNT_W-1:0] len);
      logic [COUNT_W-1:0] r;
      r = len;
      if (len < COUNT_W'(LEN_MIN)) r = COUNT_W'(LEN_MIN);
      if (len > COUNT_W'(MAX_FRAME)) r = COUNT_W'(MAX_FRAME);
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/afr_front.sv -----
`default_nettype none
module afr_front
   import afr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic              req_opcode,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   output      logic              push_valid,
   input  wire logic              push_ready,
   output      entry_type         push_entry
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      take;

   assign req_ready  = !valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (valid_ff && push_ready) valid_in = 1'b0;
      if (take) begin
         valid_in      = 1'b1;
         entry_in.kind = req_opcode ? KIND_TICK : KIND_BYTE;
         entry_in.data = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// ----- design/afr_queue.sv -----
`default_nettype none
module afr_queue
   import afr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output      logic      push_ready,
   input  wire entry_type push_entry,
   output      logic      pop_valid,
   input  wire logic      pop_ready,
   output      entry_type pop_entry
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign push_ready = count_ff < QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue over capacity");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a write");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step");

endmodule
`default_nettype wire

// ----- design/afr_back.sv -----
`default_nettype none
module afr_back
   import afr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              pop_valid,
   output      logic              pop_ready,
   input  wire entry_type         pop_entry,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic              rsp_frame_ok,
   output      logic [1:0]        rsp_error_cause,
   output      logic [BYTE_W-1:0] rsp_command_flag,
   output      logic [WORD_W-1:0] rsp_data_word
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TICK_W-1:0]  idle_ff, idle_in, idle_sat;
   logic [BYTE_W-1:0]  acc_ff, acc_in, base_acc;
   cause_type          err_ff, err_in, base_err, final_err;
   logic [BYTE_W-1:0]  flag_ff, flag_in, base_flag;
   logic [WORD_W-1:0]  word_ff, word_in, base_word;

   logic               out_valid_ff, out_valid_in;
   cause_type          out_err_ff, out_err_in;
   logic [BYTE_W-1:0]  out_flag_ff, out_flag_in;
   logic [WORD_W-1:0]  out_word_ff, out_word_in;

   logic               step, first, last;
   logic [COUNT_W-1:0] len;
   logic [BYTE_W-1:0]  b;

   // only a closing byte needs the response register free
   assign pop_ready = !out_valid_ff || rsp_ready || pop_entry.kind == KIND_TICK || !last;
   assign step      = pop_valid && pop_ready;
   assign b         = pop_entry.data;
   assign len       = eff_length(cfg.frame_length);
   assign first     = count_ff == '0;
   assign last      = count_ff >= len - 1'b1;

   // a new frame starts from clean capture state
   assign base_err  = first ? ERR_NONE : err_ff;
   assign base_acc  = first ? cfg.sync_byte : acc_ff;
   assign base_flag = first ? '0 : flag_ff;
   assign base_word = first ? '0 : word_ff;
   assign idle_sat  = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
   assign final_err = (base_err == ERR_NONE && base_acc != b) ? ERR_SUM : base_err;

   always_comb begin
      count_in     = count_ff;
      idle_in      = idle_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      flag_in      = flag_ff;
      word_in      = word_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_err_in   = out_err_ff;
      out_flag_in  = out_flag_ff;
      out_word_in  = out_word_ff;
      if (step) begin
         if (pop_entry.kind == KIND_TICK) begin
            if (!first) begin
               if (idle_sat >= cfg.timeout_ticks) begin
                  count_in = '0;
                  idle_in  = '0;
               end else begin
                  idle_in = idle_sat;
               end
            end
         end else if (last) begin
            out_valid_in = 1'b1;
            out_err_in   = final_err;
            out_flag_in  = base_flag;
            out_word_in  = base_word;
            count_in     = '0;
            idle_in      = '0;
         end else begin
            err_in  = base_err;
            acc_in  = base_acc;
            flag_in = base_flag;
            word_in = base_word;
            if (first) begin
               idle_in = '0;
            end else begin
               if (count_ff < COUNT_W'(START_COUNT)) begin
                  if (b != cfg.sync_byte && base_err == ERR_NONE) err_in = ERR_START;
               end else if (count_ff == COUNT_W'(START_COUNT)) begin
                  if (b != cfg.device_address && base_err == ERR_NONE) err_in = ERR_ADDR;
               end else if (count_ff == COUNT_W'(START_COUNT + 1)) begin
                  flag_in = b;
               end else if (count_ff == COUNT_W'(START_COUNT + 2)) begin
                  word_in = {b, base_word[BYTE_W-1:0]};
               end else if (count_ff == COUNT_W'(START_COUNT + 3)) begin
                  word_in = {base_word[WORD_W-1:BYTE_W], b};
               end
               acc_in = base_acc ^ b;
            end
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idle_ff      <= '0;
         acc_ff       <= '0;
         err_ff       <= ERR_NONE;
         flag_ff      <= '0;
         word_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idle_ff      <= idle_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         flag_ff      <= flag_in;
         word_ff      <= word_in;
         out_valid_ff <= out_valid_in;
      end
      out_err_ff  <= out_err_in;
      out_flag_ff <= out_flag_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_ok     = out_err_ff == ERR_NONE;
   assign rsp_error_cause  = out_err_ff;
   assign rsp_command_flag = out_flag_ff;
   assign rsp_data_word    = out_word_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < COUNT_W'(MAX_FRAME))
      else $error("byte count past longest frame");

   a_tick_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (step && pop_entry.kind == KIND_TICK) |=> !$rose(out_valid_ff))
      else $error("tick produced a response");

   a_rsp_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && pop_entry.kind == KIND_BYTE && last) |=> count_ff == '0 && idle_ff == '0)
      else $error("frame end did not restart the count");

endmodule
`default_nettype wire

// ----- design/addressed_frame_receiver_xor_check_top.sv -----
`default_nettype none
// Addressed frame receiver with XOR checksum. Each request is either a received
// byte (opcode 0) or a one-millisecond tick (opcode 1). Bytes are counted into
// frames of frame_length bytes (clamped to 7..64). Byte 0 is taken unchecked, byte 1
// must equal the sync byte register, byte 2 must equal device_address, byte 3 is
// the command flag and bytes 4/5 form a big-endian data word. A running XOR seeded
// with the sync byte covers bytes 1..n-2 and must match the last byte. The last
// byte of a frame yields one response with frame_ok, the first failure cause, the
// flag and the word; every other request yields none. A partial frame is dropped
// silently once timeout_ticks ticks have arrived since its first byte. Throughput
// is one request per clock while no closing byte waits on the response register:
// an input register classifies the request, a two-entry queue decouples it from
// the frame engine, and the engine updates its state into a response register.
// While a response waits to be taken, ticks and bytes that do not close a frame
// keep flowing; only a closing byte waits for the response register to free up.
// A response is registered behind the input register and the queue. Configuration
// writes are always accepted and must only be issued while the block is idle.
module addressed_frame_receiver_xor_check_top
   import afr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic              req_opcode,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   // response channel
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic              rsp_frame_ok,
   output      logic [1:0]        rsp_error_cause,
   output      logic [BYTE_W-1:0] rsp_command_flag,
   output      logic [WORD_W-1:0] rsp_data_word,
   // register write channel
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [TICK_W-1:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_LENGTH:   cfg_in.frame_length   = csr_wdata[COUNT_W-1:0];
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata[BYTE_W-1:0];
            CSR_SYNC_BYTE:      cfg_in.sync_byte      = csr_wdata[BYTE_W-1:0];
            CSR_TIMEOUT_TICKS:  cfg_in.timeout_ticks  = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length   <= COUNT_W'(9);
         cfg_ff.device_address <= '0;
         cfg_ff.sync_byte      <= '0;
         cfg_ff.timeout_ticks  <= TICK_W'(100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify and register the request
   afr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   // decoupling queue
   afr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // frame engine and response register
   afr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_error_cause  (rsp_error_cause),
      .rsp_command_flag (rsp_command_flag),
      .rsp_data_word    (rsp_data_word)
   );

endmodule
`default_nettype wire
